### src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescape block
// Item structs, parser phases, status codes and character helpers.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       string_done;
        logic [2:0] status;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOQUOTE = 3'd1,
        ST_ESCAPE  = 3'd2,
        ST_HEX     = 3'd3,
        ST_UNTERM  = 3'd4
    } t_status;

    typedef struct packed {
        t_phase     phase;
        logic [1:0] hex_left;
        logic [7:0] code_low;
        t_status    error_code;
    } t_state;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LOW_U = 8'h75;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_nibble;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } t_esc;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic t_nibble hex_value(input logic [7:0] b);
        t_nibble r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.ok    = 1'b1;
            r.value = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            // letters a-f / A-F: low nibble 1..6 maps to 10..15
            r.ok    = 1'b1;
            r.value = b[3:0] + 4'd9;
        end
        return r;
    endfunction

    function automatic t_esc escape_value(input logic [7:0] b);
        t_esc r;
        r.ok = 1'b1;
        case (b)
            CH_QUOTE:  r.value = CH_QUOTE;
            CH_BSLASH: r.value = CH_BSLASH;
            CH_SLASH:  r.value = CH_SLASH;
            8'h62:     r.value = 8'h08;
            8'h66:     r.value = 8'h0C;
            8'h6E:     r.value = 8'h0A;
            8'h72:     r.value = 8'h0D;
            8'h74:     r.value = 8'h09;
            default: begin
                r.ok    = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage

### src/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape: streaming JSON string literal decoder
// Skips leading whitespace, then decodes one string byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_in_valid / o_in_ready / i_in_item: one text byte or an
//   end-of-input marker per item.
//   output channel o_out_valid / i_out_ready / o_out_item: exactly one result
//   item per input item, in order (decoded byte, closing-quote flag, status).
// Timing:
//   an item is held in the input register, is decoded in one pass and lands
//   in the result register. Throughput is one item per cycle while the
//   receiver keeps i_out_ready high; the single decode step that updates
//   the parser state is the only path between the two registers.
// Reset:
//   synchronous, active low; parser waits for an opening quote, no error,
//   both registers empty.
// Stall:
//   while the receiver holds i_out_ready low the result stays put, the input
//   register still takes one more item, then o_in_ready drops until the
//   result is taken. Errors are sticky until reset.
// ----------------------------------------------------------------------------
module json_string_unescape (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  jsu_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output jsu_pkg::t_out_item o_out_item
);

    logic               r_in_valid;
    jsu_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    jsu_pkg::t_out_item r_out_item;
    jsu_pkg::t_state    r_state;
    jsu_pkg::t_state    n_state;
    jsu_pkg::t_out_item n_out_item;
    logic               w_advance;

    jsu_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    // item moves on when the result register is free or being emptied
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: jsu_pkg::PH_WAIT, hex_left: 2'd0,
                             code_low: 8'h00, error_code: jsu_pkg::ST_OK};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (w_advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### src/jsu_step.sv
// ----------------------------------------------------------------------------
// jsu_step: one-byte decode step
// Next parser state and result item for one input item, purely combinational.
// ----------------------------------------------------------------------------
module jsu_step (
    input  jsu_pkg::t_state    i_state,
    input  jsu_pkg::t_in_item  i_item,
    output jsu_pkg::t_state    o_state,
    output jsu_pkg::t_out_item o_result
);

    jsu_pkg::t_nibble w_hex;
    jsu_pkg::t_esc    w_esc;
    logic [7:0]       w_code;

    assign w_hex  = jsu_pkg::hex_value(i_item.in_byte);
    assign w_esc  = jsu_pkg::escape_value(i_item.in_byte);
    assign w_code = {i_state.code_low[3:0], w_hex.value};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_state.error_code == jsu_pkg::ST_OK) begin
            if (i_item.kind == jsu_pkg::KIND_END) begin
                o_state.error_code = (i_state.phase == jsu_pkg::PH_WAIT) ?
                                     jsu_pkg::ST_NOQUOTE : jsu_pkg::ST_UNTERM;
            end else begin
                case (i_state.phase)
                    jsu_pkg::PH_WAIT: begin
                        if (i_item.in_byte == jsu_pkg::CH_QUOTE) begin
                            o_state.phase = jsu_pkg::PH_STR;
                        end else if (!jsu_pkg::is_space(i_item.in_byte)) begin
                            o_state.error_code = jsu_pkg::ST_NOQUOTE;
                        end
                    end
                    jsu_pkg::PH_STR: begin
                        if (i_item.in_byte == jsu_pkg::CH_QUOTE) begin
                            o_result.string_done = 1'b1;
                            o_state.phase        = jsu_pkg::PH_WAIT;
                        end else if (i_item.in_byte == jsu_pkg::CH_BSLASH) begin
                            o_state.phase = jsu_pkg::PH_ESC;
                        end else begin
                            o_result.out_char   = i_item.in_byte;
                            o_result.char_valid = 1'b1;
                        end
                    end
                    jsu_pkg::PH_ESC: begin
                        if (i_item.in_byte == jsu_pkg::CH_LOW_U) begin
                            o_state.phase    = jsu_pkg::PH_HEX;
                            o_state.hex_left = 2'd3;
                            o_state.code_low = 8'h00;
                        end else if (!w_esc.ok) begin
                            o_state.error_code = jsu_pkg::ST_ESCAPE;
                        end else begin
                            o_result.out_char   = w_esc.value;
                            o_result.char_valid = 1'b1;
                            o_state.phase       = jsu_pkg::PH_STR;
                        end
                    end
                    default: begin
                        if (!w_hex.ok) begin
                            o_state.error_code = jsu_pkg::ST_HEX;
                        end else begin
                            o_state.code_low = w_code;
                            if (i_state.hex_left == 2'd0) begin
                                o_result.out_char   = w_code;
                                o_result.char_valid = 1'b1;
                                o_state.phase       = jsu_pkg::PH_STR;
                            end else begin
                                o_state.hex_left = i_state.hex_left - 2'd1;
                            end
                        end
                    end
                endcase
            end
        end
        if (o_state.error_code != jsu_pkg::ST_OK) begin
            o_result        = '0;
            o_result.status = o_state.error_code;
        end
    end

endmodule

### src/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker: port-level checks for json_string_unescape
// Result stability under stall, field consistency, sticky errors and ready input.
// ----------------------------------------------------------------------------
module jsu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input jsu_pkg::t_out_item o_out_item
);

    logic r_err_seen;

    // remember that an error result has been delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
        end else if (o_out_valid && i_out_ready &&
                     o_out_item.status != jsu_pkg::ST_OK) begin
            r_err_seen <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.char_valid |->
            o_out_item.status == jsu_pkg::ST_OK && !o_out_item.string_done)
        else $error("decoded byte alongside error or closing quote");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != jsu_pkg::ST_OK |->
            o_out_item.out_char == 8'h00 && !o_out_item.string_done)
        else $error("error result carries data");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_err_seen |-> o_out_item.status != jsu_pkg::ST_OK)
        else $error("error status cleared without reset");

    a_in_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && i_in_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
